// File: rtl/lfpp_pkg.sv
// ----------------------------------------------------------------------------
// lfpp_pkg
// Shared constants and controller/datapath handshake types for the LED frame
// packet parser.
// ----------------------------------------------------------------------------
package lfpp_pkg;

   // header layout
   localparam logic [7:0] MAGIC_0     = 8'h4C;  // 'L'
   localparam logic [7:0] MAGIC_1     = 8'h45;  // 'E'
   localparam logic [7:0] MAGIC_2     = 8'h44;  // 'D'
   localparam logic [7:0] VERSION_ONE = 8'h01;
   localparam int         HDR_LEN     = 5;
   localparam int         MIN_LEN     = 6;

   localparam int CHAN_IDX_W  = 4;
   localparam int BYTE_W      = 8;
   localparam int PKT_TOTAL_W = 32;

   // controller to datapath
   typedef struct packed {
      logic recv;   // byte channel open
      logic eval;   // decide frame form, restart channel counter
      logic read;   // fetch the current channel from the head store
      logic load;   // move fetched channel into the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_taken;  // final byte of a packet transferred
      logic chan_last;   // channel counter at the final channel
      logic slot_free;   // result register can take a new item
   } status_type;

endpackage

// File: rtl/lfpp_req_if.sv
// ----------------------------------------------------------------------------
// lfpp_req_if
// Packet byte channel: valid/ready handshake with one byte and an end flag.
// ----------------------------------------------------------------------------
interface lfpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

// File: rtl/lfpp_rsp_if.sv
// ----------------------------------------------------------------------------
// lfpp_rsp_if
// Channel result channel: valid/ready handshake with one brightness value.
// ----------------------------------------------------------------------------
interface lfpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  channel_index;
   logic [7:0]  channel_value;
   logic        frame_parsed;
   logic        frame_last;
   logic [31:0] packet_total;

   modport source (output valid, output channel_index, output channel_value,
                   output frame_parsed, output frame_last, output packet_total,
                   input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input frame_parsed, input frame_last, input packet_total,
                   output ready);
endinterface

// File: rtl/lfpp_ctrl.sv
// ----------------------------------------------------------------------------
// lfpp_ctrl
// Sequencer: receives a packet, decides the frame form, then walks the
// channels one by one through the head store read and the result register.
// ----------------------------------------------------------------------------
module lfpp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  lfpp_pkg::status_type status,
   output lfpp_pkg::cmd_type    cmd
);
   import lfpp_pkg::*;

   localparam logic [1:0] ST_RECV = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_LOAD = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_RECV: begin
            cmd.recv = 1'b1;
            if (status.last_taken) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.slot_free) begin
               cmd.load = 1'b1;
               state_in = status.chan_last ? ST_RECV : ST_READ;
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/lfpp_datapath.sv
// ----------------------------------------------------------------------------
// lfpp_datapath
// Head byte store, byte and packet counters, header check and the result
// register that drives the channel output.
// ----------------------------------------------------------------------------
module lfpp_datapath #(
   parameter int CHANNELS   = 16,
   parameter int MAX_PACKET = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   lfpp_req_if.sink             req_chan,
   lfpp_rsp_if.source           rsp_chan,
   input  lfpp_pkg::cmd_type    cmd,
   output lfpp_pkg::status_type status
);
   import lfpp_pkg::*;

   localparam int HEAD_DEPTH = CHANNELS + HDR_LEN;
   localparam int AW         = $clog2(HEAD_DEPTH);
   localparam int LW         = $clog2(MAX_PACKET + 1);
   localparam int CIW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMPW       = (LW > 9) ? LW : 9;

   logic [LW-1:0]  count_ff;
   logic [LW-1:0]  len_ff;
   logic [7:0]     hdr_ff [HDR_LEN];
   logic [7:0]     mem [HEAD_DEPTH];
   logic [31:0]    packets_ff;
   logic           parsed_ff;
   logic [7:0]     cnt_ff;
   logic [CIW-1:0] chan_ff;
   logic [7:0]     rd_data_ff;
   logic           rd_ok_ff;
   logic           rsp_valid_ff;
   logic [3:0]     rsp_index_ff;
   logic [7:0]     rsp_value_ff;
   logic           rsp_parsed_ff;
   logic           rsp_last_ff;
   logic [31:0]    rsp_total_ff;

   logic           take;
   logic           below_max;
   logic [LW-1:0]  count_inc;
   logic           parsed_in;
   logic [AW-1:0]  rd_addr;
   logic           rd_ok;
   logic           chan_last;
   logic           rsp_xfer;

   assign req_chan.ready = cmd.recv;
   assign take           = req_chan.valid & cmd.recv;
   assign below_max      = (count_ff < LW'(MAX_PACKET));
   assign count_inc      = below_max ? count_ff + 1'b1 : count_ff;
   assign chan_last      = (chan_ff == CIW'(CHANNELS - 1));
   assign rsp_xfer       = rsp_valid_ff & rsp_chan.ready;

   assign status.last_taken = take & req_chan.last_byte;
   assign status.chan_last  = chan_last;
   assign status.slot_free  = ~rsp_valid_ff | rsp_chan.ready;

   // header form check on the stored packet
   always_comb begin
      parsed_in = (CMPW'(len_ff) >= CMPW'(MIN_LEN))
                & (hdr_ff[0] == MAGIC_0)
                & (hdr_ff[1] == MAGIC_1)
                & (hdr_ff[2] == MAGIC_2)
                & (hdr_ff[3] == VERSION_ONE)
                & (hdr_ff[4] != 8'd0)
                & (CMPW'(len_ff) >= CMPW'(hdr_ff[4]) + CMPW'(HDR_LEN));
   end

   // parsed form skips the header, raw form reads from the start
   always_comb begin
      if (parsed_ff) begin
         rd_addr = AW'(chan_ff) + AW'(HDR_LEN);
         rd_ok   = (CMPW'(chan_ff) < CMPW'(cnt_ff));
      end else begin
         rd_addr = AW'(chan_ff);
         rd_ok   = (CMPW'(chan_ff) < CMPW'(len_ff));
      end
   end

   // byte counting and header capture
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         packets_ff <= '0;
      end else if (take) begin
         count_ff <= req_chan.last_byte ? '0 : count_inc;
         if (req_chan.last_byte) begin
            packets_ff <= packets_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         if (req_chan.last_byte) begin
            len_ff <= count_inc;
         end
         if (count_ff < LW'(HDR_LEN)) begin
            hdr_ff[count_ff[2:0]] <= req_chan.byte_value;
         end
      end
   end

   // head byte store
   always_ff @(posedge clock) begin
      if (take && (CMPW'(count_ff) < CMPW'(HEAD_DEPTH))) begin
         mem[AW'(count_ff)] <= req_chan.byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_data_ff <= mem[rd_addr];
         rd_ok_ff   <= rd_ok;
      end
   end

   // frame decision and channel walk
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         parsed_ff <= parsed_in;
         cnt_ff    <= hdr_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '0;
      end else if (cmd.eval) begin
         chan_ff <= '0;
      end else if (cmd.load && !chan_last) begin
         chan_ff <= chan_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_index_ff  <= CHAN_IDX_W'(chan_ff);
         rsp_value_ff  <= rd_ok_ff ? rd_data_ff : 8'd0;
         rsp_parsed_ff <= parsed_ff;
         rsp_last_ff   <= chan_last;
         rsp_total_ff  <= packets_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.channel_index = rsp_index_ff;
   assign rsp_chan.channel_value = rsp_value_ff;
   assign rsp_chan.frame_parsed  = rsp_parsed_ff;
   assign rsp_chan.frame_last    = rsp_last_ff;
   assign rsp_chan.packet_total  = rsp_total_ff;

endmodule

// File: rtl/led_frame_packet_parser.sv
// Packet bytes are taken one per cycle while a packet streams in.
// After the final byte the input stalls for the readout: a decision step,
// then per channel a head store read and a result register load, the load
// waiting while the result register holds an untaken result. Reset clears
// the byte and packet counters and the sequencer; the head byte store is not
// cleared.
// ----------------------------------------------------------------------------
// led_frame_packet_parser
// Collects a packet's head bytes and emits one brightness result per channel,
// in header form or as a raw frame.
// ----------------------------------------------------------------------------
module led_frame_packet_parser #(
   parameter int CHANNELS   = 16,
   parameter int MAX_PACKET = 512
) (
   input  logic        clock,
   input  logic        reset,
   lfpp_req_if.sink    req_chan,
   lfpp_rsp_if.source  rsp_chan
);
   import lfpp_pkg::*;

   cmd_type    cmd;
   status_type status;

   lfpp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   lfpp_datapath #(
      .CHANNELS   (CHANNELS),
      .MAX_PACKET (MAX_PACKET)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .status   (status)
   );

endmodule
